/* hdl/kbkc_pkg.sv */
`timescale 1ns / 1ps

package kbkc_pkg;

   localparam int KEY_ROUNDS = 4;

   localparam int BYTE_W    = 8;
   localparam int DATA_W    = 8;
   localparam int KEY_W     = 64;
   localparam int ROUND_W   = 16;
   localparam int POS_W     = 31;
   localparam int START_W   = 34;
   localparam int LEN_W     = 31;
   localparam int MULT_W    = 15;
   localparam int SIZE_W    = 23;
   localparam int SIZE3_W   = 24;
   localparam int CSR_IDX_W = 2;

   // Length divide by 102400 = 4096 * 25: shift out 12 bits, then multiply
   // by the rounded-up reciprocal of 25 scaled by 2^24. For 19-bit operands
   // the error term stays below one, so the quotient is exact.
   localparam int          DIV_SHIFT      = 12;
   localparam int          DIV_Y_W        = LEN_W - DIV_SHIFT;
   localparam int          RECIP_W        = 20;
   localparam int          DIV_PROD_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(671089);

   localparam logic [BYTE_W-1:0] SIZE_BIAS = BYTE_W'(3);

   localparam logic [CSR_IDX_W-1:0] CSR_CIPHER_KEY    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_LENGTH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE  = CSR_IDX_W'(2);

   typedef struct packed {
      logic [KEY_W-1:0]                     key;
      logic                                 decrypt;
      logic [KEY_ROUNDS-1:0][SIZE_W-1:0]    size;
      logic [KEY_ROUNDS-1:0][SIZE3_W-1:0]   size3;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0]                 data;
      logic [KEY_ROUNDS-1:0][BYTE_W-1:0] s_lo;
      logic [BYTE_W-1:0]                 p_lo;
   } item_type;

endpackage

/* hdl/kbkc_csr.sv */
`timescale 1ns / 1ps

module kbkc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kbkc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kbkc_pkg::KEY_W-1:0]         csr_wdata,
   output kbkc_pkg::cfg_type                  cfg
);
   import kbkc_pkg::*;

   logic [KEY_W-1:0]  key_ff;
   logic [MULT_W-1:0] mult_ff;
   logic [MULT_W-1:0] mult_in;
   logic              decrypt_ff;

   logic [DIV_Y_W-1:0]         len_hi;
   logic [DIV_Y_W+RECIP_W-1:0] len_prod;

   logic [KEY_ROUNDS-1:0][SIZE_W-1:0]  size_ff;
   logic [KEY_ROUNDS-1:0][SIZE_W-1:0]  size_in;
   logic [KEY_ROUNDS-1:0][SIZE3_W-1:0] size3_ff;
   logic [KEY_ROUNDS-1:0][SIZE3_W-1:0] size3_in;

   assign csr_ready = 1'b1;

   // The piece size multiplier is length / 102400 + 1, worked out once when
   // the length is written.
   assign len_hi   = csr_wdata[LEN_W-1:DIV_SHIFT];
   assign len_prod = len_hi * RECIP_25;
   assign mult_in  = len_prod[DIV_PROD_SHIFT +: MULT_W] + MULT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         mult_ff    <= MULT_W'(1);
         decrypt_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CIPHER_KEY:    key_ff     <= csr_wdata;
            CSR_BUFFER_LENGTH: mult_ff    <= mult_in;
            CSR_DECRYPT_MODE:  decrypt_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Piece size and three times the piece size for every round, kept in
   // registers so the request path sees only adds and compares.
   always_comb begin
      logic [BYTE_W:0]   factor;
      logic [BYTE_W+2:0] factor3;
      for (int r = 0; r < KEY_ROUNDS; r++) begin
         factor      = {1'b0, key_ff[ROUND_W*r +: BYTE_W]} + {1'b0, SIZE_BIAS};
         factor3     = {2'b00, factor} + {1'b0, factor, 1'b0};
         size_in[r]  = SIZE_W'(factor * mult_ff);
         size3_in[r] = SIZE3_W'(factor3 * mult_ff);
      end
   end

   always_ff @(posedge clock) begin
      size_ff  <= size_in;
      size3_ff <= size3_in;
   end

   assign cfg.key     = key_ff;
   assign cfg.decrypt = decrypt_ff;
   assign cfg.size    = size_ff;
   assign cfg.size3   = size3_ff;

endmodule

/* hdl/kbkc_advance.sv */
`timescale 1ns / 1ps

module kbkc_advance (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [kbkc_pkg::DATA_W-1:0]    req_data_in,
   input  logic                           req_first_byte,
   input  kbkc_pkg::cfg_type              cfg,
   output logic                           item_valid,
   input  logic                           item_ready,
   output kbkc_pkg::item_type             item
);
   import kbkc_pkg::*;

   logic              in_valid_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              in_first_ff;

   logic              item_valid_ff;
   item_type          item_ff;
   item_type          item_in;

   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   base_pos;
   logic [POS_W-1:0]   pos_in;
   logic               wrap;
   logic [START_W-1:0] start_ff [KEY_ROUNDS];
   logic [START_W-1:0] s_new    [KEY_ROUNDS];
   logic [START_W-1:0] last_bit;

   logic stage_free;
   logic move;
   logic in_free;

   assign stage_free = !item_valid_ff || item_ready;
   assign move       = in_valid_ff && stage_free;
   assign in_free    = !in_valid_ff || move;
   assign req_stall  = !in_free;

   assign base_pos = in_first_ff ? '0 : pos_ff;
   assign last_bit = {base_pos, 3'b111};
   assign pos_in   = base_pos + POS_W'(1);
   assign wrap     = (pos_in == '0);

   // Each round moves its piece start forward by whole pieces while the
   // next piece still begins at or before the last bit of this byte, at
   // most three pieces. The three candidates are compared side by side.
   always_comb begin
      logic [START_W:0] base;
      logic [START_W:0] c1;
      logic [START_W:0] c2;
      logic [START_W:0] c3;
      logic [START_W:0] lim;
      lim = {1'b0, last_bit};
      for (int r = 0; r < KEY_ROUNDS; r++) begin
         base = in_first_ff ? '0 : {1'b0, start_ff[r]};
         c1   = base + (START_W+1)'(cfg.size[r]);
         c2   = base + ((START_W+1)'(cfg.size[r]) << 1);
         c3   = base + (START_W+1)'(cfg.size3[r]);
         if (c3 <= lim) begin
            s_new[r] = c3[START_W-1:0];
         end else if (c2 <= lim) begin
            s_new[r] = c2[START_W-1:0];
         end else if (c1 <= lim) begin
            s_new[r] = c1[START_W-1:0];
         end else begin
            s_new[r] = base[START_W-1:0];
         end
      end
   end

   always_comb begin
      item_in.data = in_data_ff;
      item_in.p_lo = base_pos[BYTE_W-1:0];
      for (int r = 0; r < KEY_ROUNDS; r++) begin
         item_in.s_lo[r] = s_new[r][BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         item_valid_ff <= 1'b0;
         pos_ff        <= '0;
         for (int r = 0; r < KEY_ROUNDS; r++) begin
            start_ff[r] <= '0;
         end
      end else begin
         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (stage_free) begin
            item_valid_ff <= in_valid_ff;
         end
         if (move) begin
            pos_ff <= pos_in;
            for (int r = 0; r < KEY_ROUNDS; r++) begin
               start_ff[r] <= wrap ? '0 : s_new[r];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_data_ff  <= req_data_in;
         in_first_ff <= req_first_byte;
      end
      if (move) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

/* hdl/kbkc_mix.sv */
`timescale 1ns / 1ps

module kbkc_mix (
   input  logic                           clock,
   input  logic                           reset,
   input  kbkc_pkg::cfg_type              cfg,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  kbkc_pkg::item_type             item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [kbkc_pkg::DATA_W-1:0]    rsp_data_out
);
   import kbkc_pkg::*;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [BYTE_W-1:0] key_sum;
   logic [DATA_W-1:0] data_in;

   assign item_ready = !rsp_valid_ff || !rsp_stall;

   // Only the low byte of every term survives, so the piece start, piece
   // size and position enter as their low bytes.
   always_comb begin
      logic [BYTE_W-1:0]   off;
      logic [BYTE_W-1:0]   sz;
      logic [BYTE_W-1:0]   s;
      logic [2*BYTE_W-1:0] prod;
      logic [BYTE_W-1:0]   h;
      key_sum = '0;
      for (int r = 0; r < KEY_ROUNDS; r++) begin
         off = cfg.key[ROUND_W*r+BYTE_W +: BYTE_W];
         if (off == '0) begin
            off = BYTE_W'(1);
         end
         sz   = cfg.size[r][BYTE_W-1:0];
         s    = item.s_lo[r];
         prod = off * s;
         h    = prod[BYTE_W-1:0] + s - (sz & s) + (off | s) + (BYTE_W'(r) | sz);
         key_sum = key_sum + h + (off | item.p_lo);
      end
   end

   assign data_in = cfg.decrypt ? (item.data - key_sum) : (item.data + key_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item_ready) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (item_ready && item_valid) begin
         rsp_data_ff <= data_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;

endmodule

/* hdl/keyed_byte_keystream_cipher.sv */
`timescale 1ns / 1ps

// Byte stream cipher. Each request carries one data byte and a first-byte
// flag that restarts the byte position and all piece starts of a buffer.
// Each response carries the byte with the keystream added (encrypt) or
// subtracted (decrypt), in request order, one response per request.
// The accepting edge loads the input register; a request then passes the
// stage that advances the per-round piece starts and the response register,
// where rsp_valid rises.
// One request can be accepted every cycle while req_stall is low; the rate
// is set by the piece start update, which is computed combinationally
// because the next byte starts from it.
// The csr port (csr_ready is always high) writes the key, the buffer
// length and the mode; write it only while no request is in flight.
// A new key takes effect for requests accepted from the next cycle on.
// Reset clears key, mode, valid flags, byte position and piece starts.
// While rsp_stall is high the response holds, the pipeline fills, and
// req_stall rises once the input register is occupied.
module keyed_byte_keystream_cipher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kbkc_pkg::DATA_W-1:0]       req_data_in,
   input  logic                              req_first_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kbkc_pkg::DATA_W-1:0]       rsp_data_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kbkc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kbkc_pkg::KEY_W-1:0]        csr_wdata
);
   import kbkc_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     item_valid;
   logic     item_ready;

   kbkc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kbkc_advance u_advance (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_in    (req_data_in),
      .req_first_byte (req_first_byte),
      .cfg            (cfg),
      .item_valid     (item_valid),
      .item_ready     (item_ready),
      .item           (item)
   );

   kbkc_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .item_valid   (item_valid),
      .item_ready   (item_ready),
      .item         (item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data_out (rsp_data_out)
   );

endmodule

/* test/keyed_byte_keystream_cipher_tb.sv */
`timescale 1ns / 1ps

module keyed_byte_keystream_cipher_tb;
   import kbkc_pkg::*;

   localparam int LEN_DIVISOR = 102400;
   localparam int MAX_ADVANCE = 3;
   localparam int PIPE_DEPTH  = 3;
   localparam int PHASES      = 20;
   localparam int PHASE_BYTES = 40;
   localparam int MAX_REPORTS = 10;
   localparam int TIMEOUT_NS  = 5_000_000;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [DATA_W-1:0]    req_data_in    = '0;
   logic                 req_first_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [DATA_W-1:0]    rsp_data_out;
   logic                 csr_valid      = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [KEY_W-1:0]     csr_wdata      = '0;

   keyed_byte_keystream_cipher DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_in    (req_data_in),
      .req_first_byte (req_first_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data_out   (rsp_data_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // Shadow copy of the cipher registers and stream position.
   logic [KEY_W-1:0]   key_reg;
   logic [LEN_W-1:0]   len_reg;
   logic               decrypt_reg;
   logic [POS_W-1:0]   byte_pos;
   logic [START_W-1:0] piece_start [KEY_ROUNDS];

   logic [DATA_W-1:0]  expected_bytes [$];
   logic [DATA_W-1:0]  rsp_want;
   int                 bytes_sent    = 0;
   int                 bytes_checked = 0;
   int                 mismatches    = 0;
   bit                 steady_source = 1'b0;
   bit                 steady_sink   = 1'b0;
   int unsigned        stall_left    = 0;

   typedef struct {
      bit                   is_csr;
      logic [CSR_IDX_W-1:0] idx;
      logic [KEY_W-1:0]     wdata;
      logic [DATA_W-1:0]    data;
      logic                 first;
      bit                   typed;
      logic [DATA_W-1:0]    want;
   } plan_row_type;

   plan_row_type plan [$];

   function automatic void reset_position();
      int r;
      byte_pos = '0;
      for (r = 0; r < KEY_ROUNDS; r++)
         piece_start[r] = '0;
   endfunction

   function automatic logic [DATA_W-1:0] cipher_byte(input logic [DATA_W-1:0] data,
                                                     input logic first);
      logic [63:0] mult;
      logic [63:0] pos;
      logic [63:0] last_bit;
      logic [63:0] size;
      logic [63:0] offs;
      logic [63:0] s;
      logic [63:0] sum;
      int          r;
      int          k;
      sum  = '0;
      mult = 64'(len_reg) / 64'(LEN_DIVISOR) + 64'd1;
      if (first)
         reset_position();
      pos      = 64'(byte_pos);
      last_bit = (pos << 3) + 64'd7;
      for (r = 0; r < KEY_ROUNDS; r++) begin
         size = (64'(key_reg[ROUND_W*r +: BYTE_W]) + 64'(SIZE_BIAS)) * mult;
         offs = 64'(key_reg[ROUND_W*r + BYTE_W +: BYTE_W]);
         if (offs == 64'd0)
            offs = 64'd1;
         // The piece holding the last bit of this byte is at most a few
         // pieces ahead of where the previous byte left off.
         s = 64'(piece_start[r]);
         for (k = 0; k < MAX_ADVANCE; k++)
            if (s + size <= last_bit)
               s = s + size;
         piece_start[r] = s[START_W-1:0];
         s   = 64'(piece_start[r]);
         sum = sum + offs * s + s - (size & s) + (offs | s)
               + ((64'(r) | size) & 64'hFF) + (offs | pos);
      end
      byte_pos = byte_pos + POS_W'(1);
      if (byte_pos == '0)
         reset_position();
      return decrypt_reg ? data - sum[DATA_W-1:0] : data + sum[DATA_W-1:0];
   endfunction

   function automatic int unsigned idle_len();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Response side backpressure.
   always @(posedge clock) begin
      if (steady_sink) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall  <= 1'b0;
         stall_left <= idle_len();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response data_out 0x%02h with no request outstanding",
                        $time, rsp_data_out);
         end else begin
            rsp_want = expected_bytes.pop_front();
            if (rsp_data_out !== rsp_want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: response %0d data_out expected 0x%02h, got 0x%02h",
                           $time, bytes_checked, rsp_want, rsp_data_out);
            end
            bytes_checked++;
         end
      end
   end

   task automatic send_byte(input logic [DATA_W-1:0] data, input logic first,
                            input bit typed, input logic [DATA_W-1:0] want);
      logic [DATA_W-1:0] predicted;
      int unsigned       gap;
      req_valid      <= 1'b1;
      req_data_in    <= data;
      req_first_byte <= first;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = cipher_byte(data, first);
      expected_bytes.push_back(typed ? want : predicted);
      bytes_sent++;
      gap = steady_source ? 0 : idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 1) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         CSR_CIPHER_KEY:    key_reg = value;
         CSR_BUFFER_LENGTH: len_reg = value[LEN_W-1:0];
         CSR_DECRYPT_MODE:  decrypt_reg = value[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [KEY_W-1:0] key_val;
      logic [KEY_W-1:0] len_val;
      logic             first_flag;
      int               phase;
      int               n;
      int               run_left;

      key_reg     = '0;
      len_reg     = '0;
      decrypt_reg = 1'b0;
      reset_position();

      // is_csr, index, wdata, data, first, typed, want
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h00, 1'b0, 1'b1, 8'h54});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'hFF, 1'b1, 1'b1, 8'h53});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h80, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h01, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h7F, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b1, CSR_DECRYPT_MODE, 64'd1, 8'h00, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h54, 1'b1, 1'b1, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h00, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b1, CSR_CIPHER_KEY, '1, 8'h00, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'hFF, 1'b1, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h00, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'hAA, 1'b0, 1'b0, 8'h00});
      // A four byte buffer, then bytes past its end.
      plan.push_back('{1'b1, CSR_BUFFER_LENGTH, 64'd4, 8'h00, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h11, 1'b1, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h22, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h33, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h44, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h55, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h66, 1'b0, 1'b0, 8'h00});
      // Zero offset bytes stand for an offset of one.
      plan.push_back('{1'b1, CSR_CIPHER_KEY, 64'h0000_00FF_0000_0080, 8'h00, 1'b0, 1'b0,
                       8'h00});
      plan.push_back('{1'b1, CSR_DECRYPT_MODE, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h5A, 1'b1, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'hA5, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'hC3, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b1, CSR_BUFFER_LENGTH, 64'h7FFF_FFFF, 8'h00, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h0F, 1'b1, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'hF0, 1'b0, 1'b0, 8'h00});
      // New key in the middle of a buffer, without a restart.
      plan.push_back('{1'b1, CSR_CIPHER_KEY, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0,
                       8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h3C, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'hC3, 1'b0, 1'b0, 8'h00});
      plan.push_back('{1'b0, CSR_CIPHER_KEY, '0, 8'h96, 1'b0, 1'b0, 8'h00});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr)
            write_reg(plan[i].idx, plan[i].wdata);
         else
            send_byte(plan[i].data, plan[i].first, plan[i].typed, plan[i].want);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: key_val = '0;
            1: key_val = '1;
            2: key_val = {$urandom, $urandom} & 64'hFF00_FF00_FF00_FF00;
            3: key_val = {$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF;
            default: key_val = {$urandom, $urandom};
         endcase
         // Mostly lengths below one divisor step, so pieces stay short.
         case ($urandom_range(0, 9))
            0, 1, 2, 3: len_val = 64'($urandom_range(0, LEN_DIVISOR - 1));
            4: len_val = 64'd0;
            5: len_val = 64'h7FFF_FFFF;
            6: len_val = {$urandom, $urandom};
            7: len_val = 64'($urandom_range(1, 20) * LEN_DIVISOR);
            default: len_val = 64'($urandom_range(1, 20) * LEN_DIVISOR - 1);
         endcase
         write_reg(CSR_CIPHER_KEY, key_val);
         write_reg(CSR_BUFFER_LENGTH, len_val);
         write_reg(CSR_DECRYPT_MODE, 64'($urandom_range(0, 1)));

         steady_source = (phase % 5 == 4);
         steady_sink   = (phase % 5 == 4);
         // Some phases carry on with the buffer that was open before the write.
         run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
         for (n = 0; n < PHASE_BYTES; n++) begin
            if (run_left == 0) begin
               first_flag = 1'b1;
               run_left   = $urandom_range(1, 48);
            end else begin
               first_flag = 1'b0;
            end
            if ($urandom_range(0, 19) == 0)
               first_flag = ~first_flag;
            run_left--;
            send_byte(8'($urandom_range(0, 255)), first_flag, 1'b0, 8'h00);
            if (n == PHASE_BYTES / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
               drain();
         end
         steady_source = 1'b0;
         steady_sink   = 1'b0;
      end

      req_valid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      repeat (4 * PIPE_DEPTH) @(posedge clock);

      $display("%0d requests sent over %0d random phases plus the directed table,", bytes_sent,
               PHASES);
      $display("%0d responses checked in both modes, %0d mismatches", bytes_checked,
               mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
hdl/kbkc_pkg.sv
hdl/kbkc_csr.sv
hdl/kbkc_advance.sv
hdl/kbkc_mix.sv
hdl/keyed_byte_keystream_cipher.sv
test/keyed_byte_keystream_cipher_tb.sv
